>>> hw/rtl/brt_pkg.sv
// Shared types and constants for the bad-block remap table.
package brt_pkg;

   localparam int OFS_W       = 40;
   localparam int SUM_W       = OFS_W + 1;
   localparam int BLOCK_W     = 32;
   localparam int POS_W       = 24;
   localparam int JPOS_W      = 10;
   localparam int LOG2_W      = 5;
   localparam int SPARE_W     = 7;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 112;
   localparam int RSP_PAD_W   = RSP_TDATA_W - (OFS_W + 1 + JPOS_W + BLOCK_W + POS_W);
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   localparam logic [LOG2_W-1:0]  LOG2_MIN      = 5'd9;
   localparam logic [LOG2_W-1:0]  LOG2_MAX      = 5'd24;
   localparam logic [LOG2_W-1:0]  LOG2_RESET    = 5'd17;
   localparam logic [SPARE_W-1:0] SPARE_RESET   = 7'd16;
   localparam int                 SPARE_MIN     = 2;
   localparam logic [JPOS_W-1:0]  JOURNAL_START = 10'd4;
   localparam logic [JPOS_W-1:0]  ENTRY_BYTES   = 10'd8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLOCK_SIZE_LOG2 = 1'd0,
      CSR_SPARE_BLOCKS    = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_TRANSLATE = 2'd0,
      CMD_REMAP     = 2'd1,
      CMD_REPLAY    = 2'd2,
      CMD_SKIP      = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   typedef struct packed {
      command_type         command;
      logic [BLOCK_W-1:0]  entry_block;
      logic [POS_W-1:0]    pos;
      logic [BLOCK_W-1:0]  block;
      logic [OFS_W-1:0]    phys_default;
   } op_type;

   typedef struct packed {
      logic                status;
      logic [POS_W-1:0]    copy_bytes;
      logic [BLOCK_W-1:0]  journal_block;
      logic [JPOS_W-1:0]   journal_address;
      logic                journal_write;
      logic [OFS_W-1:0]    physical_offset;
   } rsp_type;

endpackage

>>> hw/rtl/brt_ram.sv
// Generic RAM with one write port and one registered read port.
module brt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/brt_front.sv
// Front stage: accept a request, shift the offset past the spare region, split block and position.
module brt_front import brt_pkg::*; #(
   parameter int OFFSET_BITS = 40,
   parameter int SP_W        = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic [LOG2_W-1:0]      eff_lg,
   input  logic [SP_W-1:0]        eff_sp,
   output logic                   push_valid,
   input  logic                   push_ready,
   output op_type                 push_op
);

   localparam int          MASK_BITS = (OFFSET_BITS < SUM_W) ? OFFSET_BITS : SUM_W;
   localparam logic [SUM_W:0] MASK_WIDE = (SUM_W+1)'(((SUM_W+1)'(1) << MASK_BITS) - (SUM_W+1)'(1));
   localparam logic [SUM_W-1:0] OFS_MASK = MASK_WIDE[SUM_W-1:0];

   logic               valid_ff, valid_in;
   command_type        cmd_ff;
   logic [SUM_W-1:0]   shifted_ff, shifted_in;
   logic [BLOCK_W-1:0] eblk_ff;
   logic               take;

   assign req_tready = !valid_ff || push_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      shifted_in = (SUM_W'(req_tdata[OFS_W-1:0]) + (SUM_W'(eff_sp) << eff_lg)) & OFS_MASK;
      valid_in   = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff     <= command_type'(req_tuser);
         shifted_ff <= shifted_in;
         eblk_ff    <= req_tdata[OFS_W +: BLOCK_W];
      end
   end

   always_comb begin
      push_op.command      = cmd_ff;
      push_op.entry_block  = eblk_ff;
      push_op.pos          = shifted_ff[POS_W-1:0] & ~({POS_W{1'b1}} << eff_lg);
      push_op.block        = BLOCK_W'(shifted_ff >> eff_lg);
      push_op.phys_default = shifted_ff[OFS_W-1:0];
   end

   assign push_valid = valid_ff;

endmodule

>>> hw/rtl/brt_queue.sv
// Short FIFO of decoded operations between the front and back stages.
module brt_queue import brt_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push_valid,
   output logic   push_ready,
   input  op_type push_op,
   output logic   pop_valid,
   input  logic   pop_ready,
   output op_type pop_op
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   op_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_op     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

>>> hw/rtl/brt_back.sv
// Back stage: slot table, journal position, newest-match scan and response register.
module brt_back import brt_pkg::*; #(
   parameter int MAX_SPARE   = 64,
   parameter int OFFSET_BITS = 40,
   parameter int SP_W        = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [LOG2_W-1:0]      eff_lg,
   input  logic [SP_W-1:0]        eff_sp,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  op_type                 pop_op,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [0:0]             rsp_tuser
);

   localparam int AW        = $clog2(MAX_SPARE);
   localparam int SLOT_W    = $clog2(MAX_SPARE + 1);
   localparam int MASK_BITS = (OFFSET_BITS < OFS_W) ? OFFSET_BITS : OFS_W;
   localparam logic [OFS_W:0] MASK_WIDE =
      (OFS_W+1)'(((OFS_W+1)'(1) << MASK_BITS) - (OFS_W+1)'(1));
   localparam logic [OFS_W-1:0] PHYS_MASK = MASK_WIDE[OFS_W-1:0];

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  next_slot_ff, next_slot_in;
   logic [JPOS_W-1:0]  jpos_ff, jpos_in;
   logic [AW-1:0]      idx_ff, idx_in;
   op_type             op_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_load;
   logic               out_free;
   logic               take;
   logic               full;
   logic               ram_wr_en;
   logic [BLOCK_W-1:0] ram_wr_data;
   logic [AW-1:0]      ram_rd_addr;
   logic [BLOCK_W-1:0] ram_rd_data;

   function automatic logic [OFS_W-1:0] place(input logic [AW-1:0] slot,
                                              input logic [LOG2_W-1:0] lg,
                                              input logic [POS_W-1:0] pos);
      return ((OFS_W'(slot) << lg) | OFS_W'(pos)) & PHYS_MASK;
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pop_ready = (state_ff == ST_IDLE) && out_free;
   assign take      = pop_valid && pop_ready;
   assign full      = SP_W'(next_slot_ff) >= eff_sp;

   always_comb begin
      state_in     = state_ff;
      next_slot_in = next_slot_ff;
      jpos_in      = jpos_ff;
      idx_in       = idx_ff;
      rsp_load     = 1'b0;
      rsp_in       = '0;
      ram_wr_en    = 1'b0;
      ram_wr_data  = pop_op.block;
      ram_rd_addr  = idx_ff - 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            ram_rd_addr = AW'(next_slot_ff - 1'b1);
            if (take) begin
               unique case (pop_op.command)
                  CMD_TRANSLATE: begin
                     if (next_slot_ff > SLOT_W'(1)) begin
                        idx_in   = AW'(next_slot_ff - 1'b1);
                        state_in = ST_SCAN;
                     end else begin
                        rsp_load               = 1'b1;
                        rsp_in.physical_offset = pop_op.phys_default;
                     end
                  end
                  CMD_REMAP: begin
                     rsp_load = 1'b1;
                     if (full) begin
                        rsp_in.status = 1'b1;
                     end else begin
                        ram_wr_en              = 1'b1;
                        rsp_in.physical_offset =
                           place(next_slot_ff[AW-1:0], eff_lg, pop_op.pos);
                        rsp_in.journal_write   = 1'b1;
                        rsp_in.journal_address = jpos_ff;
                        rsp_in.journal_block   = pop_op.block;
                        rsp_in.copy_bytes      = pop_op.pos;
                        next_slot_in           = next_slot_ff + 1'b1;
                        jpos_in                = jpos_ff + ENTRY_BYTES;
                     end
                  end
                  CMD_REPLAY: begin
                     rsp_load = 1'b1;
                     if (full) begin
                        rsp_in.status = 1'b1;
                     end else begin
                        ram_wr_en    = 1'b1;
                        ram_wr_data  = pop_op.entry_block;
                        next_slot_in = next_slot_ff + 1'b1;
                        jpos_in      = jpos_ff + ENTRY_BYTES;
                     end
                  end
                  CMD_SKIP: begin
                     rsp_load = 1'b1;
                     jpos_in  = jpos_ff + ENTRY_BYTES;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (ram_rd_data == op_ff.block) begin
               rsp_load               = 1'b1;
               rsp_in.physical_offset = place(idx_ff, eff_lg, op_ff.pos);
               state_in               = ST_IDLE;
            end else if (idx_ff == AW'(1)) begin
               rsp_load               = 1'b1;
               rsp_in.physical_offset = op_ff.phys_default;
               state_in               = ST_IDLE;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         next_slot_ff <= SLOT_W'(1);
         jpos_ff      <= JOURNAL_START;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_slot_ff <= next_slot_in;
         jpos_ff      <= jpos_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff <= pop_op;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   brt_ram #(
      .WIDTH (BLOCK_W),
      .DEPTH (MAX_SPARE)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (next_slot_ff[AW-1:0]),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_ff.status;
   assign rsp_tdata    = {{RSP_PAD_W{1'b0}}, rsp_ff.copy_bytes, rsp_ff.journal_block,
                          rsp_ff.journal_address, rsp_ff.journal_write,
                          rsp_ff.physical_offset};

`ifndef ASSERT_OFF
   a_scan_out_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !rsp_valid_ff)
      else $error("response pending during slot scan");

   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> (idx_ff != '0 && SLOT_W'(idx_ff) < next_slot_ff))
      else $error("scan index outside written slots");

   a_journal_align: assert property (@(posedge clock) disable iff (reset)
      jpos_ff[2:0] == JOURNAL_START[2:0])
      else $error("journal position lost entry alignment");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      next_slot_ff != '0 && next_slot_ff <= SLOT_W'(MAX_SPARE))
      else $error("next slot out of range");
`endif

endmodule

>>> hw/rtl/bad_block_remap_table.sv
// Top level of the flash bad-block remap table.
//
//   channel  direction  handshake             payload
//   req      in         req_tvalid/tready     tdata: logical_offset, entry_block
//                                             tuser: command
//   rsp      out        rsp_tvalid/tready     tdata: physical_offset ... copy_bytes
//                                             tuser: status
//   csr      in         csr_valid/ready       csr_index, csr_data
//
// Front stage takes one request per cycle into a two-entry queue while that queue has room.
// Back stage: remap, replay and skip answer straight from idle; translate scans the written slots
// newest first, from next_slot - 1 down to slot 1, through the slot RAM read port.
// Synchronous reset; the slot RAM is not cleared, only written slots are compared.
// A waiting response stalls only the back stage; the front keeps filling the queue.
module bad_block_remap_table import brt_pkg::*; #(
   parameter int MAX_SPARE   = 64,
   parameter int OFFSET_BITS = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // logical_offset[39:0], entry_block[71:40]
   input  logic [1:0]             req_tuser,  // command[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // physical_offset[39:0], journal_write[40],
                                              // journal_address[50:41],
                                              // journal_block[82:51], copy_bytes[106:83]
   output logic [0:0]             rsp_tuser,  // status[0]
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int SLOT_W = $clog2(MAX_SPARE + 1);
   localparam int SP_W   = (SLOT_W > SPARE_W) ? SLOT_W : SPARE_W;

   logic [LOG2_W-1:0]  lg_ff, lg_in;
   logic [SPARE_W-1:0] sp_ff, sp_in;
   logic [LOG2_W-1:0]  eff_lg;
   logic [SP_W-1:0]    sp_ext;
   logic [SP_W-1:0]    eff_sp;
   logic               push_valid, push_ready;
   op_type             push_op;
   logic               pop_valid, pop_ready;
   op_type             pop_op;

   assign csr_ready = 1'b1;

   always_comb begin
      lg_in = lg_ff;
      sp_in = sp_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BLOCK_SIZE_LOG2: lg_in = csr_data[LOG2_W-1:0];
            CSR_SPARE_BLOCKS:    sp_in = csr_data[SPARE_W-1:0];
            default:             lg_in = lg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_ff <= LOG2_RESET;
         sp_ff <= SPARE_RESET;
      end else begin
         lg_ff <= lg_in;
         sp_ff <= sp_in;
      end
   end

   always_comb begin
      sp_ext = SP_W'(sp_ff);
      priority if (lg_ff < LOG2_MIN) begin
         eff_lg = LOG2_MIN;
      end else if (lg_ff > LOG2_MAX) begin
         eff_lg = LOG2_MAX;
      end else begin
         eff_lg = lg_ff;
      end
      priority if (sp_ext < SP_W'(SPARE_MIN)) begin
         eff_sp = SP_W'(SPARE_MIN);
      end else if (sp_ext > SP_W'(MAX_SPARE)) begin
         eff_sp = SP_W'(MAX_SPARE);
      end else begin
         eff_sp = sp_ext;
      end
   end

   brt_front #(
      .OFFSET_BITS (OFFSET_BITS),
      .SP_W        (SP_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .eff_lg     (eff_lg),
      .eff_sp     (eff_sp),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op)
   );

   brt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   brt_back #(
      .MAX_SPARE   (MAX_SPARE),
      .OFFSET_BITS (OFFSET_BITS),
      .SP_W        (SP_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .eff_lg     (eff_lg),
      .eff_sp     (eff_sp),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
